// ===== sv/srl_pkg.sv =====
package srl_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ID_W  = 32;
  localparam int unsigned AGE_W = 8;
  localparam int unsigned POS_W = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY_POS = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } rec_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [ID_W-1:0]  key;
    logic [AGE_W-1:0] age;
  } cell_op_t;

  typedef struct packed {
    logic gt;
    logic ge;
    logic match;
  } cell_flags_t;

endpackage

// ===== sv/srl_if.sv =====
interface srl_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic signed [srl_pkg::ID_W-1:0]     key_id;
  logic [srl_pkg::AGE_W-1:0]           age_in;
  logic [srl_pkg::POS_W-1:0]           position;

  modport source (output valid, command, key_id, age_in, position, input ready);
  modport sink (input valid, command, key_id, age_in, position, output ready);
endinterface

interface srl_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [srl_pkg::ID_W-1:0]     out_id;
  logic [srl_pkg::AGE_W-1:0]           out_age;
  logic [srl_pkg::CNT_W-1:0]           occupancy;

  modport source (output valid, status, out_id, out_age, occupancy, input ready);
  modport sink (input valid, status, out_id, out_age, occupancy, output ready);
endinterface

// ===== sv/srl_cell.sv =====
module srl_cell (
  input  logic                  clk,
  input  srl_pkg::cell_op_t     op,
  input  logic                  occ,
  input  logic                  gt_left,
  input  srl_pkg::rec_t         left_rec,
  input  srl_pkg::rec_t         right_rec,
  output srl_pkg::cell_flags_t  flags,
  output srl_pkg::rec_t         rec
);

  srl_pkg::rec_t rec_r;
  srl_pkg::rec_t rec_nxt;
  logic          gt;

  assign gt          = !occ || ($signed(rec_r.id) > $signed(op.key));
  assign flags.gt    = gt;
  assign flags.ge    = occ && ($signed(rec_r.id) >= $signed(op.key));
  assign flags.match = occ && (rec_r.id == op.key);
  assign rec         = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    priority if (op.ins) begin
      // take the new record at the first slot past it, shift the rest up
      if (gt_left) begin
        rec_nxt = left_rec;
      end else if (gt) begin
        rec_nxt.id  = op.key;
        rec_nxt.age = op.age;
      end
    end else if (op.del) begin
      if (flags.ge) begin
        rec_nxt = right_rec;
      end
    end else begin
      rec_nxt = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ===== sv/sorted_record_list.sv =====
// Each accepted item's result is registered into the output register.
// Throughput: one item per cycle while the result side takes each result;
// every cell of the chain compares and shifts in the same cycle.
// Reset (synchronous, rst_n low) empties the table and drops any pending result;
// record contents are not cleared and no clearing pass is needed.
module sorted_record_list (
  input  logic       clk,
  input  logic       rst_n,
  srl_in_if.sink     in_chan,
  srl_out_if.source  out_chan
);

  localparam int unsigned DEPTH = srl_pkg::DEPTH;
  localparam int unsigned CNT_W = srl_pkg::CNT_W;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic [1:0]             status_r;
  logic [1:0]             status_nxt;
  logic [srl_pkg::ID_W-1:0]  id_r;
  logic [srl_pkg::ID_W-1:0]  id_nxt;
  logic [srl_pkg::AGE_W-1:0] age_r;
  logic [srl_pkg::AGE_W-1:0] age_nxt;
  logic [CNT_W-1:0]       occ_r;

  logic                   fire;
  logic                   full;
  logic                   found;
  srl_pkg::cmd_t          cmd;
  srl_pkg::cell_op_t      op;
  srl_pkg::rec_t          rec_w   [DEPTH];
  srl_pkg::cell_flags_t   flags_w [DEPTH];
  logic [DEPTH-1:0]       occ_w;
  logic [DEPTH-1:0]       match_w;
  srl_pkg::rec_t          rd_rec;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;
  assign cmd           = srl_pkg::cmd_t'(in_chan.command);
  assign full          = (count_r == CNT_W'(DEPTH));
  assign found         = |match_w;

  assign op.ins = fire && (cmd == srl_pkg::CMD_INSERT) && !full;
  assign op.del = fire && (cmd == srl_pkg::CMD_DELETE) && found;
  assign op.key = in_chan.key_id;
  assign op.age = in_chan.age_in;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      srl_pkg::rec_t left_rec;
      srl_pkg::rec_t right_rec;
      logic          gt_left;

      assign occ_w[i]   = (CNT_W'(i) < count_r);
      assign match_w[i] = flags_w[i].match;

      if (i == 0) begin : g_first
        assign gt_left  = 1'b0;
        assign left_rec = rec_w[i];
      end else begin : g_mid
        assign gt_left  = flags_w[i-1].gt;
        assign left_rec = rec_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_rec = rec_w[i];
      end else begin : g_body
        assign right_rec = rec_w[i+1];
      end

      srl_cell u_cell (
        .clk      (clk),
        .op       (op),
        .occ      (occ_w[i]),
        .gt_left  (gt_left),
        .left_rec (left_rec),
        .right_rec(right_rec),
        .flags    (flags_w[i]),
        .rec      (rec_w[i])
      );
    end
  endgenerate

  assign rd_rec = rec_w[in_chan.position[srl_pkg::IDX_W-1:0]];

  always_comb begin
    count_nxt  = count_r;
    status_nxt = srl_pkg::ST_OK;
    id_nxt     = '0;
    age_nxt    = '0;
    unique case (cmd)
      srl_pkg::CMD_INSERT: begin
        if (full) begin
          status_nxt = srl_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      srl_pkg::CMD_DELETE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = srl_pkg::ST_NOT_FOUND;
        end
      end
      srl_pkg::CMD_READ: begin
        if (CNT_W'(in_chan.position) < count_r) begin
          id_nxt  = rd_rec.id;
          age_nxt = rd_rec.age;
        end else begin
          status_nxt = srl_pkg::ST_EMPTY_POS;
        end
      end
      default: begin
        status_nxt = srl_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
      age_r    <= age_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.out_id    = id_r;
  assign out_chan.out_age   = age_r;
  assign out_chan.occupancy = occ_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("record count above table depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == srl_pkg::ST_FULL) |-> occ_r == CNT_W'(DEPTH))
    else $error("full status with free slots");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  import srl_pkg::*;

  typedef struct {
    status_t                 status;
    logic signed [ID_W-1:0]  id;
    logic [AGE_W-1:0]        age;
    logic [CNT_W-1:0]        occupancy;
  } list_result_t;

  class sorted_table_model;
    logic signed [ID_W-1:0] ids [DEPTH];
    logic [AGE_W-1:0]       ages [DEPTH];
    int unsigned            count;
    list_result_t           expected_results [$];
    int unsigned            errors;
    int unsigned            n_insert, n_delete, n_read, n_nop;
    int unsigned            n_full, n_not_found, n_empty_pos, peak_count;

    function new();
      count = 0;
      errors = 0;
      n_insert = 0; n_delete = 0; n_read = 0; n_nop = 0;
      n_full = 0; n_not_found = 0; n_empty_pos = 0; peak_count = 0;
    endfunction

    function void note_item(cmd_t cmd, logic signed [ID_W-1:0] key,
                            logic [AGE_W-1:0] age, logic [POS_W-1:0] pos);
      list_result_t r;
      int unsigned  slot;
      r.status = ST_OK;
      r.id = '0;
      r.age = '0;
      case (cmd)
        CMD_INSERT: begin
          n_insert++;
          if (count >= DEPTH) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            slot = 0;
            while (slot < count && ids[slot] <= key) slot++;
            for (int i = count; i > slot; i--) begin
              ids[i] = ids[i-1];
              ages[i] = ages[i-1];
            end
            ids[slot] = key;
            ages[slot] = age;
            count++;
          end
        end
        CMD_DELETE: begin
          n_delete++;
          slot = 0;
          while (slot < count && ids[slot] != key) slot++;
          if (slot >= count) begin
            r.status = ST_NOT_FOUND;
            n_not_found++;
          end else begin
            for (int i = slot; i + 1 < count; i++) begin
              ids[i] = ids[i+1];
              ages[i] = ages[i+1];
            end
            count--;
          end
        end
        CMD_READ: begin
          n_read++;
          if (pos < count) begin
            r.id = ids[pos];
            r.age = ages[pos];
          end else begin
            r.status = ST_EMPTY_POS;
            n_empty_pos++;
          end
        end
        default: n_nop++;
      endcase
      if (count > peak_count) peak_count = count;
      r.occupancy = count[CNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic signed [ID_W-1:0] id,
                               logic [AGE_W-1:0] age, logic [CNT_W-1:0] occ);
      list_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item pending: status %0d id %0h age %0h occ %0d",
                 $time, status, id, age, occ);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (id !== e.id) begin
        $display("%0t: out_id expected %0h actual %0h", $time, e.id, id);
        errors++;
      end
      if (age !== e.age) begin
        $display("%0t: out_age expected %0h actual %0h", $time, e.age, age);
        errors++;
      end
      if (occ !== e.occupancy) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, occ);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function logic signed [ID_W-1:0] held_id();
      if (count == 0) return 0;
      return ids[$urandom_range(0, count - 1)];
    endfunction
  endclass

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1000;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned results_seen;

  srl_in_if  in_if ();
  srl_out_if out_if ();

  sorted_record_list u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  sorted_table_model table_model = new();

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [ID_W-1:0] pool_id();
    return $signed($urandom_range(0, 10)) - 5;
  endfunction

  function automatic logic signed [ID_W-1:0] insert_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return pool_id();
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic signed [ID_W-1:0] key,
                           logic [AGE_W-1:0] age, logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.key_id   <= key;
    in_if.age_in   <= age;
    in_if.position <= pos;
    do @(posedge clk); while (!in_if.ready);
    table_model.note_item(cmd, key, age, pos);
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (table_model.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(int unsigned phase_kind);
    int unsigned r;
    int unsigned pos;
    logic signed [ID_W-1:0] key;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_item(CMD_NOP, $urandom, AGE_W'($urandom), POS_W'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if ((phase_kind == 0 && r < 75) || (phase_kind == 1 && r < 15) ||
        (phase_kind == 2 && r < 40)) begin
      send_item(CMD_INSERT, insert_id(), AGE_W'($urandom), POS_W'($urandom));
    end else if ((phase_kind == 0 && r < 85) || (phase_kind == 1 && r < 80) ||
                 (phase_kind == 2 && r < 70)) begin
      r = $urandom_range(0, 99);
      if (r < 60) key = table_model.held_id();
      else if (r < 85) key = pool_id();
      else key = $urandom;
      send_item(CMD_DELETE, key, AGE_W'($urandom), POS_W'($urandom));
    end else begin
      if ($urandom_range(0, 99) < 70 && table_model.count > 0)
        pos = $urandom_range(0, table_model.count - 1);
      else
        pos = $urandom_range(0, 63);
      send_item(CMD_READ, $urandom, AGE_W'($urandom), pos[POS_W-1:0]);
    end
  endtask

  initial begin
    forever begin
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        table_model.check_result(out_if.status, out_if.out_id, out_if.out_age,
                                 out_if.occupancy);
        results_seen++;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_kind;
    int unsigned phase_len;
    int unsigned phase_no;
    idle_cycles = 0;
    items_sent = 0;
    results_seen = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.command  <= CMD_NOP;
    in_if.key_id   <= '0;
    in_if.age_in   <= '0;
    in_if.position <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_READ,   0, 8'h00, 6'd0);
    send_item(CMD_READ,   0, 8'h00, 6'd63);
    send_item(CMD_DELETE, 0, 8'h00, 6'd0);
    send_item(CMD_NOP,    -1, 8'hff, 6'h3f);
    send_item(CMD_INSERT, 32'sh8000_0000, 8'h00, 6'd0);
    send_item(CMD_INSERT, 32'sh7fff_ffff, 8'hff, 6'h3f);
    send_item(CMD_INSERT, 0, 8'h55, 6'd0);
    send_item(CMD_INSERT, 0, 8'haa, 6'd0);
    send_item(CMD_INSERT, -1, 8'h0f, 6'd0);
    for (int p = 0; p < 6; p++) send_item(CMD_READ, 0, 8'h00, p[POS_W-1:0]);
    send_item(CMD_DELETE, 0, 8'h00, 6'd0);
    send_item(CMD_READ,   0, 8'h00, 6'd2);
    send_item(CMD_DELETE, 12345, 8'h00, 6'd0);
    send_item(CMD_DELETE, 32'sh8000_0000, 8'h00, 6'd0);
    send_item(CMD_DELETE, 32'sh7fff_ffff, 8'h00, 6'd0);
    send_item(CMD_READ,   0, 8'h00, 6'd63);
    drain_results();

    phase_no = 0;
    while (items_sent < RANDOM_ITEMS + 25) begin
      phase_kind = (phase_no == 0) ? 0 : $urandom_range(0, 2);
      phase_len = (phase_kind == 2) ? $urandom_range(30, 80) : $urandom_range(70, 120);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_random(phase_kind);
      if (phase_no % 4 == 1 || $urandom_range(0, 4) == 0) drain_results();
      phase_no++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (5) @(posedge clk);
    $display("Ran %0d items (%0d inserts, %0d deletes, %0d reads, %0d no-ops), %0d results",
             items_sent, table_model.n_insert, table_model.n_delete, table_model.n_read,
             table_model.n_nop, results_seen);
    $display("Peak occupancy %0d; %0d full inserts, %0d missed deletes, %0d empty reads",
             table_model.peak_count, table_model.n_full, table_model.n_not_found,
             table_model.n_empty_pos);
    if (table_model.errors == 0 && table_model.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/srl_pkg.sv
sv/srl_if.sv
sv/srl_cell.sv
sv/sorted_record_list.sv
tb/tb.sv
